@@ rtl/core/bfs_hop_distance_graph_or_complement_unit_defines.svh @@
// Assertion macros used by the checker file of the hop-distance unit
`ifndef BFS_HOP_DISTANCE_GRAPH_OR_COMPLEMENT_UNIT_DEFINES_SVH
`define BFS_HOP_DISTANCE_GRAPH_OR_COMPLEMENT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bhd_pkg.sv @@
// Package with types and constants of the hop-distance unit
package bhd_pkg;

    localparam int MAX_NODES = 256;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int DIST_W    = NODE_W;
    localparam int QENT_W    = NODE_W + DIST_W;

    localparam logic [CNT_W-1:0]        NODE_COUNT_RST = CNT_W'(2);
    localparam logic signed [CNT_W-1:0] HOP_UNREACHED  = -(CNT_W'(1));
    localparam logic [DIST_W-1:0]       DIST_MAX       = '1;

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [DIST_W-1:0]    dist_t;
    typedef logic [MAX_NODES-1:0] row_t;

    typedef enum logic {
        REQ_ADD = 1'b0,
        REQ_RUN = 1'b1
    } req_kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD_A,
        ST_ADD_WR_A,
        ST_ADD_RD_B,
        ST_ADD_WR_B,
        ST_RUN_START,
        ST_RUN_COMP,
        ST_DEQ,
        ST_DEQ_WAIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        node_t node;
        dist_t depth;
    } qent_t;

    typedef struct packed {
        logic  we;
        node_t waddr;
        row_t  wdata;
        logic  re;
        node_t raddr;
    } adj_ctl_t;

    typedef struct packed {
        logic  we;
        node_t waddr;
        qent_t wdata;
        logic  re;
        node_t raddr;
    } q_ctl_t;

endpackage

@@ rtl/core/bhd_req_if.sv @@
// Request channel interface of the hop-distance unit
interface bhd_req_if;
    import bhd_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [CNT_W-1:0] node_a;
    logic [CNT_W-1:0] node_b;

    modport source (output valid, req_type, node_a, node_b, input ready);
    modport sink   (input valid, req_type, node_a, node_b, output ready);
endinterface

@@ rtl/core/bhd_rsp_if.sv @@
// Result channel interface of the hop-distance unit
interface bhd_rsp_if;
    import bhd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CNT_W-1:0] hop_count;
    logic                    used_complement;

    modport source (output valid, hop_count, used_complement, input ready);
    modport sink   (input valid, hop_count, used_complement, output ready);
endinterface

@@ rtl/core/bfs_hop_distance_graph_or_complement_unit.sv @@
// Top level of the hop-distance unit: sequencer, adjacency RAM and visit queue RAM
//
// Edge requests set a symmetric bit pair in a 256 x 256 adjacency bit matrix held as
// one 256-bit row per node; a run request does a breadth-first search from node 1 and
// returns the hop count to node node_count (-1 when unreachable), walking the complement
// graph when an edge joins node 1 and the target. After reset a clearing pass zeroes the
// matrix one row per cycle, and no request is taken until it is done; node_count writes
// are taken throughout. An edge request does two row read-modify-writes on the adjacency
// RAM. A run request seeds the queue with node 1 and reads its row to choose the graph;
// then for each node dequeued it does one queue read, one adjacency row read and tests
// the column bit of each node of 1..node_count, one per cycle, until the target is
// reached or the queue is found empty, and then issues the result. A finished result
// waits in an output register while edge requests go on.
module bfs_hop_distance_graph_or_complement_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bhd_pkg::CNT_W-1:0] cfg_wr_data,
    bhd_req_if.sink                   req,
    bhd_rsp_if.source                 rsp
);
    import bhd_pkg::*;

    adj_ctl_t adj_ctl;
    row_t     adj_rdata;
    q_ctl_t   q_ctl;
    qent_t    q_rdata;

    bhd_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp),
        .adj_ctl     (adj_ctl),
        .adj_rd      (adj_rdata),
        .q_ctl       (q_ctl),
        .q_rd        (q_rdata)
    );

    bhd_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_ctl.we),
        .waddr (adj_ctl.waddr),
        .wdata (adj_ctl.wdata),
        .re    (adj_ctl.re),
        .raddr (adj_ctl.raddr),
        .rdata (adj_rdata)
    );

    bhd_ram #(
        .WIDTH (QENT_W),
        .DEPTH (MAX_NODES)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_ctl.we),
        .waddr (q_ctl.waddr),
        .wdata (q_ctl.wdata),
        .re    (q_ctl.re),
        .raddr (q_ctl.raddr),
        .rdata (q_rdata)
    );
endmodule

@@ rtl/core/bhd_ram.sv @@
// Generic simple dual-port RAM with registered read
module bhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/core/bhd_engine.sv @@
// Sequencer for edge loads, clearing pass and breadth-first search
module bhd_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bhd_pkg::CNT_W-1:0] cfg_wr_data,
    bhd_req_if.sink                   req,
    bhd_rsp_if.source                 rsp,
    output bhd_pkg::adj_ctl_t         adj_ctl,
    input  bhd_pkg::row_t             adj_rd,
    output bhd_pkg::q_ctl_t           q_ctl,
    input  bhd_pkg::qent_t            q_rd
);
    import bhd_pkg::*;

    state_t                  state_reg, state_next;
    node_t                   clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]        node_count_reg, node_count_next;
    node_t                   na_reg, na_next;
    node_t                   nb_reg, nb_next;
    node_t                   n_last_reg, n_last_next;
    logic                    comp_reg, comp_next;
    logic                    found_reg, found_next;
    dist_t                   hop_reg, hop_next;
    logic [CNT_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        tail_reg, tail_next;
    node_t                   u_reg, u_next;
    dist_t                   d_reg, d_next;
    node_t                   v_reg, v_next;
    row_t                    reached_reg, reached_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [CNT_W-1:0] out_hop_reg, out_hop_next;
    logic                    out_comp_reg, out_comp_next;

    logic             accept;
    logic             ends_ok;
    logic [CNT_W-1:0] a_m1;
    logic [CNT_W-1:0] b_m1;
    logic [CNT_W-1:0] nc_m1;
    logic             nbr;
    logic             take;
    logic             last_v;
    logic             out_free;
    dist_t            d_inc;

    assign accept   = req.valid && req.ready;
    assign a_m1     = req.node_a - CNT_W'(1);
    assign b_m1     = req.node_b - CNT_W'(1);
    assign nc_m1    = node_count_reg - CNT_W'(1);
    assign ends_ok  = (req.node_a != '0) && (req.node_a <= CNT_W'(MAX_NODES))
                   && (req.node_b != '0) && (req.node_b <= CNT_W'(MAX_NODES));
    assign nbr      = comp_reg ? (!adj_rd[v_reg] && (v_reg != u_reg)) : adj_rd[v_reg];
    assign take     = !reached_reg[v_reg] && nbr;
    assign last_v   = (v_reg == n_last_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign d_inc    = (d_reg == DIST_MAX) ? DIST_MAX : d_reg + DIST_W'(1);

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.hop_count       = out_hop_reg;
    assign rsp.used_complement = out_comp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_RUN)
                    begin
                        state_next = ST_RUN_START;
                    end
                    else if (ends_ok)
                    begin
                        state_next = ST_ADD_RD_A;
                    end
                end
            end
            ST_ADD_RD_A:  state_next = ST_ADD_WR_A;
            ST_ADD_WR_A:  state_next = ST_ADD_RD_B;
            ST_ADD_RD_B:  state_next = ST_ADD_WR_B;
            ST_ADD_WR_B:  state_next = ST_IDLE;
            ST_RUN_START: state_next = ST_RUN_COMP;
            ST_RUN_COMP:  state_next = ST_DEQ;
            ST_DEQ:
            begin
                state_next = (head_reg == tail_reg) ? ST_DONE : ST_DEQ_WAIT;
            end
            ST_DEQ_WAIT:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (last_v)
                begin
                    state_next = take ? ST_DONE : ST_DEQ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        node_count_next = node_count_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        n_last_next     = n_last_reg;
        comp_next       = comp_reg;
        found_next      = found_reg;
        hop_next        = hop_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        u_next          = u_reg;
        d_next          = d_reg;
        v_next          = v_reg;
        reached_next    = reached_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_hop_next    = out_hop_reg;
        out_comp_next   = out_comp_reg;
        adj_ctl         = '0;
        q_ctl           = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                adj_ctl.we    = 1'b1;
                adj_ctl.waddr = clr_cnt_reg;
                clr_cnt_next  = clr_cnt_reg + NODE_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    na_next = a_m1[NODE_W-1:0];
                    nb_next = b_m1[NODE_W-1:0];
                    if (node_count_reg < CNT_W'(2))
                    begin
                        n_last_next = NODE_W'(1);
                    end
                    else if (node_count_reg > CNT_W'(MAX_NODES))
                    begin
                        n_last_next = NODE_W'(MAX_NODES - 1);
                    end
                    else
                    begin
                        n_last_next = nc_m1[NODE_W-1:0];
                    end
                end
            end
            ST_ADD_RD_A:
            begin
                adj_ctl.re    = 1'b1;
                adj_ctl.raddr = na_reg;
            end
            ST_ADD_WR_A:
            begin
                adj_ctl.we    = 1'b1;
                adj_ctl.waddr = na_reg;
                adj_ctl.wdata = adj_rd | (row_t'(1) << nb_reg);
            end
            ST_ADD_RD_B:
            begin
                adj_ctl.re    = 1'b1;
                adj_ctl.raddr = nb_reg;
            end
            ST_ADD_WR_B:
            begin
                adj_ctl.we    = 1'b1;
                adj_ctl.waddr = nb_reg;
                adj_ctl.wdata = adj_rd | (row_t'(1) << na_reg);
            end
            ST_RUN_START:
            begin
                reached_next    = row_t'(1);
                q_ctl.we        = 1'b1;
                q_ctl.waddr     = '0;
                q_ctl.wdata     = '0;
                head_next       = '0;
                tail_next       = CNT_W'(1);
                found_next      = 1'b0;
                adj_ctl.re      = 1'b1;
                adj_ctl.raddr   = '0;
            end
            ST_RUN_COMP:
            begin
                comp_next = adj_rd[n_last_reg];
            end
            ST_DEQ:
            begin
                if (head_reg != tail_reg)
                begin
                    q_ctl.re    = 1'b1;
                    q_ctl.raddr = head_reg[NODE_W-1:0];
                    head_next   = head_reg + CNT_W'(1);
                end
            end
            ST_DEQ_WAIT:
            begin
                u_next        = q_rd.node;
                d_next        = q_rd.depth;
                adj_ctl.re    = 1'b1;
                adj_ctl.raddr = q_rd.node;
                v_next        = '0;
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    reached_next[v_reg] = 1'b1;
                    q_ctl.we            = 1'b1;
                    q_ctl.waddr         = tail_reg[NODE_W-1:0];
                    q_ctl.wdata         = '{node: v_reg, depth: d_inc};
                    tail_next           = tail_reg + CNT_W'(1);
                    if (last_v)
                    begin
                        found_next = 1'b1;
                        hop_next   = d_inc;
                    end
                end
                v_next = v_reg + NODE_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hop_next   = found_reg ? $signed({1'b0, hop_reg}) : HOP_UNREACHED;
                    out_comp_next  = comp_reg;
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase

        if (cfg_wr_en)
        begin
            node_count_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            node_count_reg <= NODE_COUNT_RST;
            found_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            reached_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            node_count_reg <= node_count_next;
            found_reg      <= found_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            reached_reg    <= reached_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        n_last_reg   <= n_last_next;
        comp_reg     <= comp_next;
        hop_reg      <= hop_next;
        u_reg        <= u_next;
        d_reg        <= d_next;
        v_reg        <= v_next;
        out_hop_reg  <= out_hop_next;
        out_comp_reg <= out_comp_next;
    end
endmodule

@@ rtl/core/bhd_checker.sv @@
// Port-level checker for the hop-distance unit and its bind
`include "bfs_hop_distance_graph_or_complement_unit_defines.svh"

module bhd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             req_type,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic signed [bhd_pkg::CNT_W-1:0] hop_count,
    input logic                             used_complement
);
    import bhd_pkg::*;

    `BHD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(hop_count) && $stable(used_complement), "result dropped or changed while stalled")
    `BHD_ASSERT_NOW(a_hop_range, rsp_valid, !hop_count[CNT_W-1] || hop_count == HOP_UNREACHED, "hop count outside -1..255")
    `BHD_ASSERT_NOW(a_clear_pass, !$past(rst_n), !req_ready, "request taken before matrix clearing pass")
    `BHD_ASSERT_NEXT(a_run_busy, req_valid && req_ready && req_type == REQ_RUN, !req_ready, "request taken while search is running")
endmodule

bind bfs_hop_distance_graph_or_complement_unit bhd_checker u_bhd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_type        (req.req_type),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .hop_count       (rsp.hop_count),
    .used_complement (rsp.used_complement)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Testbench of the hop-distance unit: edge and search requests checked against a BFS predictor
module testbench;
    import bhd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 50;
    localparam int NODE_FIELD_MAX = (1 << CNT_W) - 1;
    localparam int PHASE_COUNTS [18] = '{7, 0, 16, 511, 3, 33,
                                         1, 12, 256, 24, 5, 64,
                                         9, 2, 40, 20, 130, 11};

    typedef struct packed {
        logic signed [CNT_W-1:0] hop_count;
        logic                    used_complement;
    } hop_result_t;

    class hop_scoreboard;
        bit [MAX_NODES:0]  adj [0:MAX_NODES];
        logic [CNT_W-1:0]  node_count;
        hop_result_t       expected_hops [$];
        int                failures;
        int                reports;

        function new();
            foreach (adj[i])
                adj[i] = '0;
            node_count = NODE_COUNT_RST;
            failures   = 0;
            reports    = 0;
        endfunction

        function void note_failure(string text);
            failures++;
            if (reports < 10)
            begin
                $display("%0t: %s", $realtime, text);
                reports++;
            end
        endfunction

        function hop_result_t shortest_hops();
            int          n;
            int          head;
            int          tail;
            int          u;
            int          v;
            int          level [0:MAX_NODES];
            bit          seen  [0:MAX_NODES];
            int          visit [0:MAX_NODES-1];
            hop_result_t res;
            n = node_count;
            if (n < 2)
                n = 2;
            if (n > MAX_NODES)
                n = MAX_NODES;
            foreach (seen[i])
            begin
                seen[i]  = 1'b0;
                level[i] = 0;
            end
            res.used_complement = adj[1][n];
            seen[1]  = 1'b1;
            visit[0] = 1;
            head     = 0;
            tail     = 1;
            while (head < tail)
            begin
                u = visit[head];
                head++;
                for (v = 1; v <= n; v++)
                begin
                    if (!seen[v] && tail < MAX_NODES &&
                        (res.used_complement ? (u != v && !adj[u][v]) : adj[u][v]))
                    begin
                        seen[v]     = 1'b1;
                        level[v]    = level[u] + 1;
                        visit[tail] = v;
                        tail++;
                    end
                end
            end
            if (!seen[n])
                res.hop_count = HOP_UNREACHED;
            else
                res.hop_count = CNT_W'((level[n] > DIST_MAX) ? DIST_MAX : level[n]);
            return res;
        endfunction

        function void note_request(req_kind_t kind, logic [CNT_W-1:0] a,
                                   logic [CNT_W-1:0] b);
            if (kind == REQ_RUN)
                expected_hops = {expected_hops, shortest_hops()};
            else if (a >= 1 && a <= MAX_NODES && b >= 1 && b <= MAX_NODES)
            begin
                adj[a][b] = 1'b1;
                adj[b][a] = 1'b1;
            end
        endfunction

        function void check_result(logic signed [CNT_W-1:0] hop_count, logic used_complement);
            hop_result_t want;
            if (expected_hops.size() == 0)
            begin
                note_failure($sformatf("unexpected result: hop_count %0d used_complement %0b",
                                       hop_count, used_complement));
                return;
            end
            want = expected_hops.pop_front();
            if (want.hop_count !== hop_count || want.used_complement !== used_complement)
                note_failure($sformatf({"result mismatch: expected hop_count %0d ",
                                        "used_complement %0b, got hop_count %0d ",
                                        "used_complement %0b"},
                                       want.hop_count, want.used_complement,
                                       hop_count, used_complement));
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             req_valid   = 1'b0;
    req_kind_t        req_kind_q  = REQ_ADD;
    logic [CNT_W-1:0] req_node_a  = '0;
    logic [CNT_W-1:0] req_node_b  = '0;
    logic             rsp_ready_q = 1'b0;

    int               sender_idle_pct   = 34;
    int               receiver_idle_pct = 65;
    int               hold_token        = 0;
    int               hold_seen         = 0;
    int               hold_left         = 0;
    int               cycle_count       = 0;
    hop_scoreboard    board;

    bhd_req_if req_ch ();
    bhd_rsp_if rsp_ch ();

    assign req_ch.valid    = req_valid;
    assign req_ch.req_type = req_kind_q;
    assign req_ch.node_a   = req_node_a;
    assign req_ch.node_b   = req_node_b;
    assign rsp_ch.ready    = rsp_ready_q;

    bfs_hop_distance_graph_or_complement_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready_q <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ready_q)
                board.check_result(rsp_ch.hop_count, rsp_ch.used_complement);
            if (hold_token != hold_seen)
            begin
                hold_seen   <= hold_token;
                hold_left   <= HOLD_CYCLES;
                rsp_ready_q <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left   <= hold_left - 1;
                rsp_ready_q <= 1'b0;
            end
            else
                rsp_ready_q <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic int pick_node(int n);
        int span;
        span = (n + 2 > MAX_NODES) ? MAX_NODES : n + 2;
        if ($urandom_range(99) < 75)
            return $urandom_range(1, span);
        return $urandom_range(1, MAX_NODES);
    endfunction

    function automatic int stray_node();
        if ($urandom_range(1) == 0)
            return 0;
        return $urandom_range(MAX_NODES + 1, NODE_FIELD_MAX);
    endfunction

    task automatic send_request(input req_kind_t kind, input int a, input int b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_kind_q <= kind;
        req_node_a <= CNT_W'(a);
        req_node_b <= CNT_W'(b);
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(kind, CNT_W'(a), CNT_W'(b));
    endtask

    task automatic send_search();
        send_request(REQ_RUN, $urandom_range(NODE_FIELD_MAX), $urandom_range(NODE_FIELD_MAX));
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_hops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.node_count = CNT_W'(value);
    endtask

    task automatic directed_requests();
        send_request(REQ_RUN, NODE_FIELD_MAX, 0);
        settle();
        write_node_count(5);
        send_request(REQ_ADD, 1, 3);
        send_request(REQ_ADD, 3, 4);
        send_request(REQ_ADD, 4, 5);
        send_search();
        send_request(REQ_ADD, 2, 2);
        send_request(REQ_ADD, 2, 200);
        send_search();
        send_request(REQ_ADD, 0, 5);
        send_request(REQ_ADD, 5, MAX_NODES + 1);
        send_request(REQ_ADD, NODE_FIELD_MAX, 1);
        send_request(REQ_ADD, MAX_NODES, MAX_NODES);
        send_search();
        send_request(REQ_ADD, 5, 1);
        send_request(REQ_RUN, 0, NODE_FIELD_MAX);
        settle();
        write_node_count(0);
        send_search();
        settle();
        write_node_count(1);
        send_search();
        settle();
        write_node_count(NODE_FIELD_MAX);
        send_search();
    endtask

    task automatic build_chain();
        int node;
        settle();
        write_node_count(MAX_NODES);
        send_request(REQ_ADD, 1, 6);
        for (node = 6; node < MAX_NODES; node++)
            send_request(REQ_ADD, node, node + 1);
        send_search();
        settle();
        write_node_count(MAX_NODES / 2);
        send_search();
    endtask

    task automatic stall_output();
        settle();
        write_node_count(6);
        hold_token <= hold_token + 1;
        send_search();
        repeat (6) send_request(REQ_ADD, pick_node(6), pick_node(6));
        send_search();
        repeat (6) send_request(REQ_ADD, pick_node(6), pick_node(6));
        send_search();
    endtask

    task automatic random_phase(input int setting, input int items);
        int n;
        int runs;
        int run_cap;
        int sent;
        int roll;
        int prev;
        int next_node;
        n = (setting < 2) ? 2 : (setting > MAX_NODES) ? MAX_NODES : setting;
        run_cap = (n > 100) ? 2 : items;
        runs = 0;
        sent = 0;
        settle();
        write_node_count(setting);
        while (sent < items)
        begin
            roll = $urandom_range(99);
            if (roll < 14 && runs < run_cap)
            begin
                send_search();
                runs++;
                sent++;
            end
            else if (roll < 34)
            begin
                prev = 1;
                repeat ($urandom_range(1, 4))
                begin
                    next_node = $urandom_range(2, n);
                    send_request(REQ_ADD, prev, next_node);
                    prev = next_node;
                    sent++;
                end
                send_request(REQ_ADD, prev, n);
                sent++;
                if (runs < run_cap)
                begin
                    send_search();
                    runs++;
                    sent++;
                end
            end
            else if (roll < 38)
            begin
                if ($urandom_range(1) == 0)
                    send_request(REQ_ADD, stray_node(), pick_node(n));
                else
                    send_request(REQ_ADD, pick_node(n), stray_node());
                sent++;
            end
            else
            begin
                send_request(REQ_ADD, pick_node(n), pick_node(n));
                sent++;
            end
        end
        if (runs == 0)
            send_search();
    endtask

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        directed_requests();
        build_chain();
        stall_output();
        foreach (PHASE_COUNTS[p])
        begin
            if (p == 6)
            begin
                sender_idle_pct   = 65;
                receiver_idle_pct = 34;
            end
            else if (p == 12)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            random_phase(PHASE_COUNTS[p], PHASE_ITEMS);
        end
        settle();
        if (board.failures == 0 && board.expected_hops.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
